/* rtl/core/iil_pkg.sv */
`default_nettype none

package iil_pkg;

  // Number of cells in the row, that is the most entries the list can hold.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);

  localparam int unsigned ReqW   = 3;
  localparam int unsigned PosW   = 7;
  localparam int unsigned ValW   = 32;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CountW = 7;

  typedef enum logic [ReqW-1:0] {
    REQ_INSERT     = 3'd0,
    REQ_REMOVE_POS = 3'd1,
    REQ_REMOVE_VAL = 3'd2,
    REQ_TEST       = 3'd3,
    REQ_CLEAR      = 3'd4
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [ReqW-1:0]        req_type;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]       status;
    logic signed [ValW-1:0] removed_value;
    logic                   found;
    logic [CountW-1:0]      count;
  } res_t;

  // Per-cell control: load the new value, take the left neighbour's entry
  // (the list opens a gap) or take the right neighbour's entry (a gap closes).
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/indexed_integer_list_core.sv */
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit integers held in a row of
// cells, position zero at the head. Each request (insert at a position,
// remove at a position, remove the first equal value, test for a value,
// clear) returns one result with a status, the removed value, a found flag
// and the count after the request. At the accepting edge every cell
// compares its entry with the request value; in the compare cycle that
// follows, the controller picks the first match or the position, and once
// the output register is free all cells shift or load in parallel while the
// result is registered. The input is stalled in the compare cycle, so a new
// request waits until the last one has written its result; a stalled result
// holds the request in the compare cycle until the output register frees up.
// There is no clearing pass: entries beyond the count are never read.
module indexed_integer_list_core
  import iil_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      out_res_o
);

  logic signed [ValW-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]    cell_match;
  cell_ctl_t              cell_ctl [CAPACITY];
  logic signed [ValW-1:0] ins_value;
  logic                   cmp_en;

  assign cmp_en = in_valid_i && !in_stall_o;

  iil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .match_i     (cell_match),
    .data_i      (cell_data),
    .cell_ctl_o  (cell_ctl),
    .ins_value_o (ins_value)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [ValW-1:0] left, right;

    if (k == 0) begin : g_head
      assign left = ins_value;
    end else begin : g_body
      assign left = cell_data[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right = cell_data[k];
    end else begin : g_inner
      assign right = cell_data[k+1];
    end

    iil_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl[k]),
      .ins_value_i (ins_value),
      .left_i      (left),
      .right_i     (right),
      .cmp_en_i    (cmp_en),
      .key_i       (in_req_i.value),
      .data_o      (cell_data[k]),
      .match_o     (cell_match[k])
    );
  end

endmodule

`default_nettype wire

/* rtl/core/iil_cell.sv */
`default_nettype none

module iil_cell
  import iil_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire cell_ctl_t              ctl_i,
  input  wire logic signed [ValW-1:0] ins_value_i,
  input  wire logic signed [ValW-1:0] left_i,
  input  wire logic signed [ValW-1:0] right_i,
  input  wire logic                   cmp_en_i,
  input  wire logic signed [ValW-1:0] key_i,
  output logic signed [ValW-1:0]      data_o,
  output logic                        match_o
);

  logic signed [ValW-1:0] data_q, data_d;
  logic                   match_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = ins_value_i;
    end else if (ctl_i.take_left) begin
      data_d = left_i;
    end else if (ctl_i.take_right) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (cmp_en_i) begin
      match_q <= (data_q == key_i);
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

/* rtl/core/iil_ctrl.sv */
`default_nettype none

module iil_ctrl
  import iil_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire req_t                   in_req_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output res_t                        out_res_o,
  input  wire logic [CAPACITY-1:0]    match_i,
  input  wire logic signed [ValW-1:0] data_i [CAPACITY],
  output cell_ctl_t                   cell_ctl_o [CAPACITY],
  output logic signed [ValW-1:0]      ins_value_o
);

  logic            a_valid_q;
  req_t            a_req_q;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  res_t            res_q, res_d;
  logic            accept, done;

  logic [CAPACITY-1:0] valid_mask, hits, first_hit, ge_match;
  logic [CAPACITY-1:0] at_pos, gt_pos, ge_pos;
  logic [PosW-1:0]     pos_eff;
  logic                any_hit;
  logic                do_ins, do_del_pos, do_del_val;
  logic signed [ValW-1:0] sel_value;

  // One request is in the compare cycle at a time; the cells were sampled
  // against its value at the accepting edge.
  assign in_stall_o = a_valid_q;
  assign accept     = in_valid_i && !a_valid_q;
  assign done       = a_valid_q && (!out_valid_q || !out_stall_i);

  assign pos_eff = (count_q == '0) ? '0 : a_req_q.position;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_mask
    assign valid_mask[k] = 32'(k) < 32'(count_q);
    assign at_pos[k]     = 32'(k) == 32'(pos_eff);
    assign gt_pos[k]     = 32'(k) > 32'(pos_eff);
    assign ge_pos[k]     = 32'(k) >= 32'(a_req_q.position);
  end

  // Isolate the lowest set match bit; everything at or above it shifts down.
  assign hits      = match_i & valid_mask;
  assign any_hit   = |hits;
  assign first_hit = hits & (~hits + CAPACITY'(1));
  assign ge_match  = ~(first_hit - CAPACITY'(1));

  always_comb begin
    sel_value = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_value = sel_value | (data_i[k] & {ValW{at_pos[k]}});
    end
  end

  always_comb begin
    do_ins            = 1'b0;
    do_del_pos        = 1'b0;
    do_del_val        = 1'b0;
    count_d           = count_q;
    res_d.status      = ST_OK;
    res_d.removed_value = '1;
    res_d.found       = 1'b0;
    case (req_e'(a_req_q.req_type))
      REQ_INSERT: begin
        if (32'(count_q) >= 32'(CAPACITY)) begin
          res_d.status = ST_FULL;
        end else if (32'(pos_eff) > 32'(count_q)) begin
          res_d.status = ST_RANGE;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      REQ_REMOVE_POS: begin
        if (count_q == '0) begin
          res_d.status = ST_EMPTY;
        end else if (32'(a_req_q.position) >= 32'(count_q)) begin
          res_d.status = ST_RANGE;
        end else begin
          do_del_pos          = 1'b1;
          res_d.removed_value = sel_value;
          count_d             = count_q - CntW'(1);
        end
      end
      REQ_REMOVE_VAL, REQ_TEST: begin
        if (count_q == '0) begin
          res_d.status = ST_EMPTY;
        end else if (!any_hit) begin
          res_d.status = ST_NOTFOUND;
        end else begin
          res_d.found = 1'b1;
          if (req_e'(a_req_q.req_type) == REQ_REMOVE_VAL) begin
            do_del_val = 1'b1;
            count_d    = count_q - CntW'(1);
          end
        end
      end
      REQ_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    res_d.count = CountW'(count_d);
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_ctl
    assign cell_ctl_o[k].load       = done && do_ins && at_pos[k];
    assign cell_ctl_o[k].take_left  = done && do_ins && gt_pos[k];
    assign cell_ctl_o[k].take_right = done && ((do_del_pos && ge_pos[k]) ||
                                               (do_del_val && ge_match[k]));
  end

  assign ins_value_o = a_req_q.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (done) begin
        a_valid_q <= 1'b0;
      end
      if (done) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_req_q <= in_req_i;
    end
    if (done) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

/* rtl/core/iil_checker.sv */
`default_nettype none

module iil_checker
  import iil_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire req_t in_req_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire res_t out_res_o
);

  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_res_o.count) <= 32'(CAPACITY)))
    else $error("count above capacity");

  // A match is only reported with a good status.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.found) |-> (out_res_o.status == ST_OK))
    else $error("found with error status");

  // Every refused request reports -1 as removed value.
  a_err_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_res_o.status != ST_OK)) |-> (out_res_o.removed_value == '1))
    else $error("refused request returned a value");

  // An accepted request occupies the block for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken during compare cycle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_res_o)))
    else $error("stalled result changed");

endmodule

bind indexed_integer_list_core iil_checker u_iil_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

`default_nettype wire

/* sim/indexed_integer_list_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the list core. It keeps its own copy of the list,
// works out the result of every accepted request and compares each accepted
// result with the oldest one still awaited.
module indexed_integer_list_checker
  import iil_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  req_t in_req_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  res_t out_res_i,
  output int   fail_count_o,
  output int   awaited_count_o,
  output int   list_len_o
);

  logic signed [ValW-1:0] shadow_cells [CAPACITY];
  int unsigned            shadow_len;
  res_t                   awaited_results [$];
  res_t                   want;

  // Applies one request to the shadow list and returns the result it yields.
  function automatic res_t predict_list_result(req_t r);
    res_t        res;
    int unsigned pos;
    int unsigned hit;
    int unsigned k;
    res.status        = ST_OK;
    res.removed_value = -32'sd1;
    res.found         = 1'b0;
    pos               = r.position;
    case (r.req_type)
      REQ_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // An empty list takes the value at the head whatever the position.
          if (shadow_len == 0) pos = 0;
          if (pos > shadow_len) begin
            res.status = ST_RANGE;
          end else begin
            for (k = shadow_len; k > pos; k--) shadow_cells[k] = shadow_cells[k-1];
            shadow_cells[pos] = r.value;
            shadow_len++;
          end
        end
      end
      REQ_REMOVE_POS: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          res.removed_value = shadow_cells[pos];
          for (k = pos; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k+1];
          shadow_len--;
        end
      end
      REQ_REMOVE_VAL, REQ_TEST: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hit = shadow_len;
          for (k = 0; k < shadow_len; k++) begin
            if (hit == shadow_len && shadow_cells[k] == r.value) hit = k;
          end
          if (hit == shadow_len) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.found = 1'b1;
            if (r.req_type == REQ_REMOVE_VAL) begin
              for (k = hit; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k+1];
              shadow_len--;
            end
          end
        end
      end
      REQ_CLEAR: shadow_len = 0;
      default: ;
    endcase
    res.count = shadow_len[CountW-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      shadow_len   = 0;
      fail_count_o = 0;
      awaited_results.delete();
    end else begin
      // A result can never leave in the cycle its request is taken, so the
      // result side is handled first.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (out_res_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_res_i.status);
            fail_count_o++;
          end
          if (out_res_i.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, actual %0d",
                   want.removed_value, out_res_i.removed_value);
            fail_count_o++;
          end
          if (out_res_i.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_res_i.found);
            fail_count_o++;
          end
          if (out_res_i.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_res_i.count);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) awaited_results.push_back(predict_list_result(in_req_i));
    end
    awaited_count_o = awaited_results.size();
    list_len_o      = shadow_len;
  end

endmodule

/* sim/tb_indexed_integer_list_core.sv */
`timescale 1ns / 100ps

module tb_indexed_integer_list_core;
  import iil_pkg::*;

  localparam int          HalfPeriod     = 6;
  localparam int          ResetCycles    = 9;
  localparam int          PhaseItems     = 460;
  localparam int          EpisodeItems   = 125;
  localparam int          HoldOffCycles  = 200;
  localparam int          QuietLimit     = 2000;
  localparam int          DrainCycles    = 8;
  localparam logic [2:0]  ReqUnusedFirst = 3'd5;
  localparam logic [2:0]  ReqUnusedLast  = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_req;
  logic out_valid;
  logic out_stall;
  res_t out_res;

  int   sender_idle_pct;
  int   receiver_stall_pct;
  logic hold_off_req;
  int   fail_count;
  int   awaited_count;
  int   list_len;
  int   quiet_cycles;
  int   item_idx;

  indexed_integer_list_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res)
  );

  indexed_integer_list_checker checker_inst (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_req_i        (in_req),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_res_i       (out_res),
    .fail_count_o    (fail_count),
    .awaited_count_o (awaited_count),
    .list_len_o      (list_len)
  );

  initial begin
    clk = 1'b0;
    forever #HalfPeriod clk = ~clk;
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("indexed_integer_list_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Small values repeat often, so that searches find matches and duplicates.
  function automatic logic signed [ValW-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return $signed($urandom_range(0, 19)) - 32'sd10;
    endcase
  endfunction

  // Growing episodes push the list towards full; shrinking ones drain it.
  function automatic req_t random_request(input bit growing, input int len);
    req_t        r;
    int unsigned pick;
    pick       = $urandom_range(0, 99);
    r.value    = random_value();
    r.position = PosW'($urandom_range(0, 127));
    if (pick < (growing ? 70 : 25)) begin
      r.req_type = REQ_INSERT;
      if ($urandom_range(0, 9) < 8) r.position = PosW'($urandom_range(0, len));
    end else if (pick < (growing ? 80 : 55)) begin
      r.req_type = REQ_REMOVE_POS;
      if ($urandom_range(0, 9) < 8 && len > 0) begin
        r.position = PosW'($urandom_range(0, len - 1));
      end
    end else if (pick < (growing ? 88 : 75)) begin
      r.req_type = REQ_REMOVE_VAL;
    end else if (pick < 96) begin
      r.req_type = REQ_TEST;
    end else if (pick < 98 && !growing) begin
      r.req_type = REQ_CLEAR;
    end else if (pick < 98) begin
      r.req_type = REQ_TEST;
    end else begin
      r.req_type = ReqW'($urandom_range(ReqUnusedFirst, ReqUnusedLast));
    end
    return r;
  endfunction

  initial begin
    in_valid           = 1'b0;
    in_req             = '0;
    rst_n              = 1'b0;
    hold_off_req       = 1'b0;
    sender_idle_pct    = 23;
    receiver_stall_pct = 84;
    item_idx           = 0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Requests on an empty list, then a short list built and taken apart.
    send_request('{REQ_TEST,       7'd0,   32'sd5});
    send_request('{REQ_REMOVE_POS, 7'd0,   32'sd0});
    send_request('{REQ_REMOVE_VAL, 7'd0,   32'sd0});
    send_request('{REQ_INSERT,     7'd100, 32'sh7fff_ffff});
    send_request('{REQ_INSERT,     7'd5,   32'sd9});
    send_request('{REQ_INSERT,     7'd0,   32'sh8000_0000});
    send_request('{REQ_INSERT,     7'd2,   -32'sd1});
    send_request('{REQ_INSERT,     7'd1,   32'sd0});
    send_request('{REQ_INSERT,     7'd1,   32'sd0});
    send_request('{REQ_TEST,       7'd0,   32'sd0});
    send_request('{REQ_TEST,       7'd0,   32'sd12345});
    send_request('{REQ_REMOVE_VAL, 7'd0,   32'sd0});
    send_request('{REQ_REMOVE_POS, 7'd4,   32'sd0});
    send_request('{REQ_REMOVE_POS, 7'd127, 32'sd0});
    send_request('{REQ_REMOVE_POS, 7'd3,   32'sd0});
    send_request('{REQ_REMOVE_POS, 7'd0,   32'sd0});
    for (int u = ReqUnusedFirst; u <= ReqUnusedLast; u++) begin
      send_request('{u[2:0], 7'd64, 32'sh5555_aaaa});
    end
    send_request('{REQ_CLEAR,      7'd0,   32'sd0});
    send_request('{REQ_TEST,       7'd0,   32'sd0});
    send_request('{REQ_INSERT,     7'd64,  32'sd1});
    send_request('{REQ_REMOVE_VAL, 7'd0,   32'sd2});
    send_request('{REQ_CLEAR,      7'd0,   32'sd0});

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 23;
          receiver_stall_pct = 84;
        end
        1: begin
          sender_idle_pct    = 84;
          receiver_stall_pct = 23;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          // The sender keeps offering while the result side holds off.
          hold_off_req       = 1'b1;
        end
      endcase
      repeat (PhaseItems) begin
        send_request(random_request(((item_idx / EpisodeItems) % 2) == 0, list_len));
        item_idx++;
      end
    end

    in_valid <= 1'b0;
    wait (awaited_count == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("indexed_integer_list_core test passed");
    end else begin
      $display("indexed_integer_list_core test failed");
    end
    $finish;
  end

endmodule
